>>> hw/rtl/hkrb_pkg.sv
// Shared types, codes and constant tables for the keyboard report builder.
package hkrb_pkg;

    localparam int KEYMAP_ENTRIES = 128;
    localparam int NUM_SLOTS      = 6;
    localparam int NUM_MODIFIERS  = 8;
    localparam int NAMED_LAST     = 40;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_MAP    = 2'd1,
        OP_SYMBOL = 2'd2,
        OP_CHAR   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UNKNOWN    = 3'd1,
        ST_BAD_UTF8   = 3'd2,
        ST_NOT_MAPPED = 3'd3,
        ST_NO_USAGE   = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  key_symbol;
        logic [7:0]  char_byte_0;
        logic [7:0]  char_byte_1;
        logic [7:0]  char_byte_2;
        logic [7:0]  char_byte_3;
        logic [2:0]  char_length;
        logic [6:0]  map_scancode;
        logic [15:0] keymap_value;
        logic        last_arg;
    } in_item_t;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] usage_1;
        logic [7:0] usage_2;
        logic [7:0] usage_3;
        logic [7:0] usage_4;
        logic [7:0] usage_5;
        logic [7:0] usage_6;
        logic [2:0] status;
    } out_item_t;

    // Character table access issued when an item is taken.
    typedef struct packed {
        logic       fire;
        logic       clear_all;
        logic       wr_en;
        logic [7:0] addr;
        logic [6:0] wr_data;
    } tbl_req_t;

    // Decoded item handed to the report stage.
    typedef struct packed {
        logic       fire;
        opcode_t    opcode;
        logic [5:0] key_symbol;
        logic       utf_ok;
        logic       last_arg;
    } dec_item_t;

    function automatic logic [7:0] named_usage(input logic [4:0] idx);
        logic [7:0] u;
        case (idx)
            5'd0:  u = 8'h28;
            5'd1:  u = 8'h29;
            5'd2:  u = 8'h2A;
            5'd3:  u = 8'h2B;
            5'd4:  u = 8'h39;
            5'd30: u = 8'h53;
            5'd31: u = 8'h58;
            default: u = 8'(8'h3A + 8'(idx) - 8'd5);
        endcase
        return u;
    endfunction

    function automatic logic [7:0] scancode_usage(input logic [6:0] sc);
        logic [7:0] u;
        case (sc)
            7'd0:  u = 8'h00; 7'd1:  u = 8'h29; 7'd2:  u = 8'h1E; 7'd3:  u = 8'h1F;
            7'd4:  u = 8'h20; 7'd5:  u = 8'h21; 7'd6:  u = 8'h22; 7'd7:  u = 8'h23;
            7'd8:  u = 8'h24; 7'd9:  u = 8'h25; 7'd10: u = 8'h26; 7'd11: u = 8'h27;
            7'd12: u = 8'h2D; 7'd13: u = 8'h2E; 7'd14: u = 8'h2A; 7'd15: u = 8'h2B;
            7'd16: u = 8'h14; 7'd17: u = 8'h1A; 7'd18: u = 8'h08; 7'd19: u = 8'h15;
            7'd20: u = 8'h17; 7'd21: u = 8'h1C; 7'd22: u = 8'h18; 7'd23: u = 8'h0C;
            7'd24: u = 8'h12; 7'd25: u = 8'h13; 7'd26: u = 8'h2F; 7'd27: u = 8'h30;
            7'd28: u = 8'h28; 7'd29: u = 8'h04; 7'd30: u = 8'h16; 7'd31: u = 8'h07;
            7'd32: u = 8'h09; 7'd33: u = 8'h0A; 7'd34: u = 8'h0B; 7'd35: u = 8'h0D;
            7'd36: u = 8'h0E; 7'd37: u = 8'h0F; 7'd38: u = 8'h33; 7'd39: u = 8'h34;
            7'd40: u = 8'h35; 7'd41: u = 8'hE1; 7'd42: u = 8'h1D; 7'd43: u = 8'h1B;
            7'd44: u = 8'h06; 7'd45: u = 8'h19; 7'd46: u = 8'h05; 7'd47: u = 8'h11;
            7'd48: u = 8'h10; 7'd49: u = 8'h36; 7'd50: u = 8'h37; 7'd51: u = 8'h38;
            7'd52: u = 8'hE5; 7'd53: u = 8'h55; 7'd54: u = 8'hE0; 7'd55: u = 8'h2C;
            7'd56: u = 8'h39; 7'd57: u = 8'h3A; 7'd58: u = 8'h3B; 7'd59: u = 8'h3C;
            7'd60: u = 8'h3D; 7'd61: u = 8'h3E; 7'd62: u = 8'h3F; 7'd63: u = 8'h40;
            7'd64: u = 8'h41; 7'd65: u = 8'h42; 7'd66: u = 8'h43; 7'd67: u = 8'h53;
            7'd68: u = 8'h47; 7'd69: u = 8'h5F; 7'd70: u = 8'h60; 7'd71: u = 8'h61;
            7'd72: u = 8'h56; 7'd73: u = 8'h5C; 7'd74: u = 8'h5D; 7'd75: u = 8'h5E;
            7'd76: u = 8'h57; 7'd77: u = 8'h59; 7'd78: u = 8'h5A; 7'd79: u = 8'h5B;
            7'd80: u = 8'h62; 7'd81: u = 8'h63;
            default: u = 8'h00;
        endcase
        return u;
    endfunction

endpackage

>>> hw/rtl/hkrb_char_store.sv
// Character table memory with per-entry valid flags and registered read.
module hkrb_char_store (
    input  logic              clk,
    input  logic              rst_n,
    input  hkrb_pkg::tbl_req_t req,
    output logic [6:0]        rd_scancode,
    output logic              rd_valid
);
    import hkrb_pkg::*;

    logic [6:0]   mem [256];
    logic [255:0] valid_reg;
    logic [255:0] valid_next;
    logic [6:0]   rd_data_reg;
    logic         rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.fire && req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.fire)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.fire && req.clear_all)
        begin
            valid_next = '0;
        end
        else if (req.fire && req.wr_en)
        begin
            valid_next[req.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.fire)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rd_scancode = rd_data_reg;
    assign rd_valid    = rd_valid_reg;

endmodule

>>> hw/rtl/hkrb_report_acc.sv
// Report stage: applies symbols and characters to the pending report and emits it.
module hkrb_report_acc (
    input  logic                clk,
    input  logic                rst_n,
    input  hkrb_pkg::dec_item_t dec,
    input  logic [6:0]          rd_scancode,
    input  logic                rd_valid,
    output logic                take_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output hkrb_pkg::out_item_t out_item
);
    import hkrb_pkg::*;

    logic       s1_valid_reg;
    opcode_t    s1_opcode_reg;
    logic [5:0] s1_symbol_reg;
    logic       s1_utf_ok_reg;
    logic       s1_last_reg;

    logic [7:0] usage_reg [NUM_SLOTS];
    logic [7:0] usage_next [NUM_SLOTS];
    logic [7:0] mods_reg;
    logic [7:0] mods_next;
    logic [2:0] slots_reg;
    logic [2:0] slots_next;
    logic [2:0] err_reg;
    logic [2:0] err_next;

    logic       out_valid_reg;
    out_item_t  out_item_reg;

    logic       s1_go;
    logic       active;
    logic       put;
    logic [7:0] put_usage;
    logic [7:0] rom_usage;
    logic [4:0] named_idx;

    assign s1_go      = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign take_ready = !s1_valid_reg || s1_go;
    assign rom_usage  = scancode_usage(rd_scancode);
    assign named_idx  = 5'(s1_symbol_reg - 6'd8);
    assign active     = s1_go && (err_reg == 3'(ST_OK)) && (int'(slots_reg) < NUM_SLOTS)
                        && (s1_opcode_reg == OP_SYMBOL || s1_opcode_reg == OP_CHAR);

    always_comb
    begin
        mods_next = mods_reg;
        err_next  = err_reg;
        put       = 1'b0;
        put_usage = '0;
        if (active)
        begin
            if (s1_opcode_reg == OP_SYMBOL)
            begin
                if (int'(s1_symbol_reg) < NUM_MODIFIERS)
                begin
                    mods_next = mods_reg | (8'd1 << s1_symbol_reg[2:0]);
                end
                else if (int'(s1_symbol_reg) < NAMED_LAST)
                begin
                    put       = 1'b1;
                    put_usage = named_usage(named_idx);
                end
                else
                begin
                    err_next = 3'(ST_UNKNOWN);
                end
            end
            else if (!s1_utf_ok_reg)
            begin
                err_next = 3'(ST_BAD_UTF8);
            end
            else if (!rd_valid)
            begin
                err_next = 3'(ST_NOT_MAPPED);
            end
            else if (rom_usage == 8'd0)
            begin
                err_next = 3'(ST_NO_USAGE);
            end
            else
            begin
                put       = 1'b1;
                put_usage = rom_usage;
            end
        end
        slots_next = put ? 3'(slots_reg + 3'd1) : slots_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            usage_next[i] = (put && slots_reg == 3'(i)) ? put_usage : usage_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_opcode_reg <= OP_CLEAR;
            s1_symbol_reg <= '0;
            s1_utf_ok_reg <= 1'b0;
            s1_last_reg   <= 1'b0;
            mods_reg      <= '0;
            slots_reg     <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                usage_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && !(s1_go && s1_last_reg))
            begin
                out_valid_reg <= 1'b0;
            end
            if (dec.fire)
            begin
                s1_valid_reg  <= 1'b1;
                s1_opcode_reg <= dec.opcode;
                s1_symbol_reg <= dec.key_symbol;
                s1_utf_ok_reg <= dec.utf_ok;
                s1_last_reg   <= dec.last_arg;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                if (s1_last_reg)
                begin
                    out_valid_reg <= 1'b1;
                    mods_reg      <= '0;
                    slots_reg     <= '0;
                    err_reg       <= '0;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        usage_reg[i] <= '0;
                    end
                end
                else
                begin
                    mods_reg  <= mods_next;
                    slots_reg <= slots_next;
                    err_reg   <= err_next;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        usage_reg[i] <= usage_next[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            out_item_reg.modifier_bits <= mods_next;
            out_item_reg.usage_1       <= usage_next[0];
            out_item_reg.usage_2       <= usage_next[1];
            out_item_reg.usage_3       <= usage_next[2];
            out_item_reg.usage_4       <= usage_next[3];
            out_item_reg.usage_5       <= usage_next[4];
            out_item_reg.usage_6       <= usage_next[5];
            out_item_reg.status        <= err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> hw/rtl/hid_keyboard_report_builder_unit.sv
// Top level of the boot keyboard report builder: UTF-8 decode and table access issue.
//
// Key arguments arrive one per transfer on the input channel (in_valid, in_ready,
// in_item). Each argument either maintains the character table (clear, map entry
// write) or adds to the pending report (key symbol, character). The argument marked
// last produces one report transfer on the output channel (out_valid, out_ready,
// out_item) carrying the modifier byte, six usage slots and the first error status.
// A new argument can be taken every cycle unless a last argument waits for the output
// register. The character table is a 256-entry synchronous memory read when the argument
// is taken; the report stage uses the registered read data with the registered argument,
// and a report goes from that stage register to the output register. Table writes and
// clears act at the same point, so later arguments always see them without any interlock.
// The report waits in an output register. While it is not taken, arguments that do
// not end a report keep flowing; the next last argument holds until the register
// frees. Reset empties the pipeline, the valid flags of the character table and the
// pending report; table contents stay undefined until written.
module hid_keyboard_report_builder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hkrb_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output hkrb_pkg::out_item_t out_item
);
    import hkrb_pkg::*;

    logic       fire;
    logic [2:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       c1;
    logic       c2;
    logic       c3;
    logic [20:0] cp;
    logic       utf_ok;
    tbl_req_t   req;
    dec_item_t  dec;
    logic [6:0] rd_scancode;
    logic       rd_valid;
    logic       take_ready;

    assign fire = in_valid && in_ready;
    assign len  = (in_item.char_length > 3'd4) ? 3'd4 : in_item.char_length;
    assign b0   = in_item.char_byte_0;
    assign b1   = in_item.char_byte_1;
    assign b2   = in_item.char_byte_2;
    assign b3   = in_item.char_byte_3;
    assign c1   = (b1[7:6] == 2'b10);
    assign c2   = (b2[7:6] == 2'b10);
    assign c3   = (b3[7:6] == 2'b10);

    always_comb
    begin
        cp     = '0;
        utf_ok = 1'b0;
        if (len == 3'd0)
        begin
            utf_ok = 1'b0;
        end
        else if (b0[7] == 1'b0)
        begin
            cp     = 21'(b0);
            utf_ok = 1'b1;
        end
        else if (b0[7:5] == 3'b110)
        begin
            cp     = {10'd0, b0[4:0], b1[5:0]};
            utf_ok = (len >= 3'd2) && c1 && (cp >= 21'h80);
        end
        else if (b0[7:4] == 4'b1110)
        begin
            cp     = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            utf_ok = (len >= 3'd3) && c1 && c2 && (cp >= 21'h800)
                     && !(cp >= 21'hD800 && cp <= 21'hDFFF);
        end
        else if (b0[7:3] == 5'b11110)
        begin
            cp     = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            utf_ok = (len == 3'd4) && c1 && c2 && c3 && (cp >= 21'h10000)
                     && (cp <= 21'h10FFFF);
        end
    end

    always_comb
    begin
        req.fire      = fire;
        req.clear_all = (in_item.opcode == OP_CLEAR);
        req.wr_en     = (in_item.opcode == OP_MAP)
                        && (int'(in_item.map_scancode) < KEYMAP_ENTRIES);
        req.addr      = (in_item.opcode == OP_CHAR) ? cp[7:0] : in_item.keymap_value[7:0];
        req.wr_data   = in_item.map_scancode;

        dec.fire       = fire;
        dec.opcode     = opcode_t'(in_item.opcode);
        dec.key_symbol = in_item.key_symbol;
        dec.utf_ok     = utf_ok;
        dec.last_arg   = in_item.last_arg;
    end

    hkrb_char_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rd_scancode (rd_scancode),
        .rd_valid    (rd_valid)
    );

    hkrb_report_acc u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .dec         (dec),
        .rd_scancode (rd_scancode),
        .rd_valid    (rd_valid),
        .take_ready  (take_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    assign in_ready = take_ready;

endmodule

>>> tb/hid_keyboard_report_builder_unit_tb.sv
// Self-checking testbench that predicts and checks every boot keyboard report of the builder.
module hid_keyboard_report_builder_unit_tb;
    import hkrb_pkg::*;

    localparam int RANDOM_ARGS  = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_LIMIT  = 50;
    localparam int ROM_SIZE     = 82;

    localparam logic [8*32-1:0] NAMED_KEY_USAGES = {
        8'h28, 8'h29, 8'h2A, 8'h2B, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
        8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h58
    };

    localparam logic [8*ROM_SIZE-1:0] SCANCODE_USAGES = {
        8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
        8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15,
        8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'h04,
        8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34,
        8'h35, 8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36,
        8'h37, 8'h38, 8'hE5, 8'h55, 8'hE0, 8'h2C, 8'h39, 8'h3A, 8'h3B, 8'h3C,
        8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5F,
        8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59, 8'h5A, 8'h5B,
        8'h62, 8'h63
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Shadow of the character table and of the report being collected.
    logic [6:0] shadow_scancode [256];
    logic       shadow_valid [256];
    logic [7:0] pending_slot_usage [6];
    logic [7:0] pending_mods;
    int         pending_slots;
    status_t    pending_error;

    // Table contents as the stimulus generator sees them.
    bit         gen_written [256];
    bit         gen_valid [256];
    logic [7:0] char_pool [16];

    in_item_t  key_args [$];
    int        drain_points [$];
    out_item_t expected_reports [$];

    int next_arg = 0;
    int gap_left = 0;
    int quiet_in = 0;
    int stall_left = 0;
    int quiet_out = 0;
    int args_taken = 0;
    int reports_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int status_seen [8];
    out_item_t predicted;
    out_item_t oldest;

    hid_keyboard_report_builder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic decode_char(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [2:0] len, output logic [20:0] cp);
        int          n;
        logic [31:0] v;
        n = (len > 3'd4) ? 4 : int'(len);
        cp = '0;
        if (n == 0)
            return 1'b0;
        if (b0 < 8'h80)
        begin
            cp = {13'd0, b0};
            return 1'b1;
        end
        if (b0[7:5] == 3'b110)
        begin
            if (n < 2 || b1[7:6] != 2'b10)
                return 1'b0;
            v = {21'd0, b0[4:0], b1[5:0]};
            if (v < 32'h80)
                return 1'b0;
            cp = v[20:0];
            return 1'b1;
        end
        if (b0[7:4] == 4'b1110)
        begin
            if (n < 3 || b1[7:6] != 2'b10 || b2[7:6] != 2'b10)
                return 1'b0;
            v = {16'd0, b0[3:0], b1[5:0], b2[5:0]};
            if (v < 32'h800 || (v >= 32'hD800 && v <= 32'hDFFF))
                return 1'b0;
            cp = v[20:0];
            return 1'b1;
        end
        if (b0[7:3] == 5'b11110)
        begin
            if (n < 4 || b1[7:6] != 2'b10 || b2[7:6] != 2'b10 || b3[7:6] != 2'b10)
                return 1'b0;
            v = {11'd0, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            if (v < 32'h10000 || v > 32'h10FFFF)
                return 1'b0;
            cp = v[20:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] scancode_to_usage(input logic [6:0] sc);
        if (sc >= ROM_SIZE)
            return 8'h00;
        return SCANCODE_USAGES[(ROM_SIZE - 1 - int'(sc)) * 8 +: 8];
    endfunction

    function automatic void add_usage(input logic [7:0] u);
        if (pending_slots < NUM_SLOTS)
        begin
            pending_slot_usage[pending_slots] = u;
            pending_slots++;
        end
    endfunction

    function automatic void clear_report();
        for (int k = 0; k < NUM_SLOTS; k++)
            pending_slot_usage[k] = 8'h00;
        pending_mods = 8'h00;
        pending_slots = 0;
        pending_error = ST_OK;
    endfunction

    function automatic logic predict_report(input in_item_t it, output out_item_t rpt);
        logic [20:0] cp;
        logic [7:0]  idx;
        logic [7:0]  u;
        int          sym;
        rpt = '0;
        sym = int'(it.key_symbol);
        if (it.opcode == OP_CLEAR)
        begin
            for (int k = 0; k < 256; k++)
                shadow_valid[k] = 1'b0;
        end
        else if (it.opcode == OP_MAP)
        begin
            if (it.map_scancode < KEYMAP_ENTRIES)
            begin
                shadow_scancode[it.keymap_value[7:0]] = it.map_scancode;
                shadow_valid[it.keymap_value[7:0]] = 1'b1;
            end
        end
        else if (pending_error == ST_OK && pending_slots < NUM_SLOTS)
        begin
            if (it.opcode == OP_SYMBOL)
            begin
                if (sym < NUM_MODIFIERS)
                    pending_mods[it.key_symbol[2:0]] = 1'b1;
                else if (sym < NAMED_LAST)
                    add_usage(NAMED_KEY_USAGES[(31 - (sym - NUM_MODIFIERS)) * 8 +: 8]);
                else
                    pending_error = ST_UNKNOWN;
            end
            else if (!decode_char(it.char_byte_0, it.char_byte_1, it.char_byte_2,
                                  it.char_byte_3, it.char_length, cp))
                pending_error = ST_BAD_UTF8;
            else
            begin
                idx = cp[7:0];
                if (!shadow_valid[idx])
                    pending_error = ST_NOT_MAPPED;
                else
                begin
                    u = scancode_to_usage(shadow_scancode[idx]);
                    if (u == 8'h00)
                        pending_error = ST_NO_USAGE;
                    else
                        add_usage(u);
                end
            end
        end
        if (!it.last_arg)
            return 1'b0;
        rpt.modifier_bits = pending_mods;
        rpt.usage_1 = pending_slot_usage[0];
        rpt.usage_2 = pending_slot_usage[1];
        rpt.usage_3 = pending_slot_usage[2];
        rpt.usage_4 = pending_slot_usage[3];
        rpt.usage_5 = pending_slot_usage[4];
        rpt.usage_6 = pending_slot_usage[5];
        rpt.status = pending_error;
        clear_report();
        return 1'b1;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t noise_item();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return in_item_t'(r[$bits(in_item_t)-1:0]);
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [31:0] r;
        r = $urandom;
        return {2'b10, r[5:0]};
    endfunction

    function automatic in_item_t key_arg(input int sym, input bit last);
        in_item_t it;
        it = noise_item();
        it.opcode = OP_SYMBOL;
        it.key_symbol = sym[5:0];
        it.last_arg = last;
        return it;
    endfunction

    function automatic in_item_t map_arg(input logic [7:0] idx, input logic [6:0] sc,
                                         input bit last);
        in_item_t it;
        it = noise_item();
        it.opcode = OP_MAP;
        it.map_scancode = sc;
        it.keymap_value[7:0] = idx;
        it.last_arg = last;
        return it;
    endfunction

    function automatic in_item_t clear_arg(input bit last);
        in_item_t it;
        it = noise_item();
        it.opcode = OP_CLEAR;
        it.last_arg = last;
        return it;
    endfunction

    function automatic in_item_t raw_char(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input int len, input bit last);
        in_item_t it;
        it = noise_item();
        it.opcode = OP_CHAR;
        it.char_byte_0 = b0;
        it.char_byte_1 = b1;
        it.char_byte_2 = b2;
        it.char_byte_3 = b3;
        it.char_length = len[2:0];
        it.last_arg = last;
        return it;
    endfunction

    function automatic in_item_t char_arg(input logic [20:0] cp, input bit last);
        in_item_t it;
        int       len;
        it = noise_item();
        it.opcode = OP_CHAR;
        it.last_arg = last;
        if (cp < 21'h80)
        begin
            it.char_byte_0 = cp[7:0];
            len = 1;
        end
        else if (cp < 21'h800)
        begin
            it.char_byte_0 = {3'b110, cp[10:6]};
            it.char_byte_1 = {2'b10, cp[5:0]};
            len = 2;
        end
        else if (cp < 21'h10000)
        begin
            it.char_byte_0 = {4'b1110, cp[15:12]};
            it.char_byte_1 = {2'b10, cp[11:6]};
            it.char_byte_2 = {2'b10, cp[5:0]};
            len = 3;
        end
        else
        begin
            it.char_byte_0 = {5'b11110, cp[20:18]};
            it.char_byte_1 = {2'b10, cp[17:12]};
            it.char_byte_2 = {2'b10, cp[11:6]};
            it.char_byte_3 = {2'b10, cp[5:0]};
            len = 4;
        end
        if ($urandom_range(0, 4) == 0)
            len = $urandom_range(len, 7);
        it.char_length = len[2:0];
        return it;
    endfunction

    function automatic in_item_t bad_char_arg(input bit last);
        logic [31:0] r;
        int          sel;
        r = $urandom;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return raw_char({7'b1100000, r[0]}, cont_byte(), r[15:8], r[23:16], 2, last);
            1: return raw_char(8'hE0, {3'b100, r[4:0]}, cont_byte(), r[23:16], 3, last);
            2: return raw_char(8'hED, {3'b101, r[4:0]}, cont_byte(), r[23:16], 3, last);
            3: return raw_char(8'hF0, {4'b1000, r[3:0]}, cont_byte(), cont_byte(), 4, last);
            4: return raw_char(8'hF4, {2'b10, (r[5:4] == 2'b00) ? 2'b01 : r[5:4], r[3:0]},
                               cont_byte(), cont_byte(), 4, last);
            5: return raw_char({3'b111, r[1:0], 3'b000}, cont_byte(), cont_byte(), cont_byte(),
                               $urandom_range(0, 2), last);
            6: return raw_char(8'hC3, {1'b0, r[6:0]}, r[15:8], r[23:16], 2, last);
            default: return raw_char((r[0]) ? {2'b10, r[6:1]} : {5'b11111, r[3:1]},
                                     cont_byte(), cont_byte(), cont_byte(),
                                     $urandom_range(1, 4), last);
        endcase
    endfunction

    function automatic logic [6:0] pick_scancode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 7'($urandom_range(1, ROM_SIZE - 1));
        if (r < 92)
            return 7'd0;
        return 7'($urandom_range(ROM_SIZE, 127));
    endfunction

    function automatic logic [20:0] pick_code_point();
        logic [31:0] r;
        logic [7:0]  low;
        logic [20:0] cp;
        int          plane;
        r = $urandom;
        low = ($urandom_range(0, 4) == 0) ? r[7:0] : char_pool[r[11:8]];
        plane = $urandom_range(1, 16);
        case ($urandom_range(0, 3))
            0: cp = {13'd0, low};
            1: cp = {10'd0, r[18:16], low};
            2:
            begin
                cp = {5'd0, r[23:16], low};
                if (cp[15:11] == 5'b11011)
                    cp[15:8] = 8'hE0;
            end
            default: cp = {plane[4:0], r[23:16], low};
        endcase
        return cp;
    endfunction

    // A character's never-written entry, or cleared one at refill_pct odds, is mapped first.
    task automatic push_arg(input in_item_t it, input int refill_pct);
        logic [20:0] cp;
        logic [7:0]  idx;
        if (it.opcode == OP_CHAR && decode_char(it.char_byte_0, it.char_byte_1, it.char_byte_2,
                                                 it.char_byte_3, it.char_length, cp))
        begin
            idx = cp[7:0];
            if (!gen_written[idx] || (!gen_valid[idx] && $urandom_range(0, 99) < refill_pct))
            begin
                key_args.push_back(map_arg(idx, pick_scancode(), 1'b0));
                gen_written[idx] = 1'b1;
                gen_valid[idx] = 1'b1;
            end
        end
        if (it.opcode == OP_MAP && it.map_scancode < KEYMAP_ENTRIES)
        begin
            gen_written[it.keymap_value[7:0]] = 1'b1;
            gen_valid[it.keymap_value[7:0]] = 1'b1;
        end
        if (it.opcode == OP_CLEAR)
        begin
            for (int k = 0; k < 256; k++)
                gen_valid[k] = 1'b0;
        end
        key_args.push_back(it);
    endtask

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("report %0d %s got %h expected %h",
                                    reports_checked, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (drain_points.size() != 0 && drain_points[0] == next_arg
                && (in_valid || expected_reports.size() != 0))
                in_valid <= 1'b0;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (next_arg < key_args.size())
            begin
                if (drain_points.size() != 0 && drain_points[0] == next_arg)
                    drain_points.delete(0);
                in_valid <= 1'b1;
                in_item  <= key_args[next_arg];
                next_arg++;
                if (quiet_in > 0)
                begin
                    gap_left = 0;
                    quiet_in--;
                end
                else
                begin
                    gap_left = idle_length();
                    if ($urandom_range(0, 49) == 0)
                        quiet_in = 40;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (quiet_out > 0)
                quiet_out--;
            else if ($urandom_range(0, 3) == 0)
                stall_left = idle_length();
            else if ($urandom_range(0, 99) == 0)
                quiet_out = 60;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (predict_report(in_item, predicted))
                    expected_reports.push_back(predicted);
                args_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                    flag_mismatch("report transfer with no report pending");
                else
                begin
                    oldest = expected_reports.pop_front();
                    compare_field("modifier_bits", out_item.modifier_bits, oldest.modifier_bits);
                    compare_field("usage_1", out_item.usage_1, oldest.usage_1);
                    compare_field("usage_2", out_item.usage_2, oldest.usage_2);
                    compare_field("usage_3", out_item.usage_3, oldest.usage_3);
                    compare_field("usage_4", out_item.usage_4, oldest.usage_4);
                    compare_field("usage_5", out_item.usage_5, oldest.usage_5);
                    compare_field("usage_6", out_item.usage_6, oldest.usage_6);
                    compare_field("status", {5'd0, out_item.status}, {5'd0, oldest.status});
                    status_seen[oldest.status]++;
                    reports_checked++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int    target;
        int    half_mark;
        int    nargs;
        int    r;
        bit    last;
        bit    mid_drain_set;
        logic [31:0] rv;
        in_item_t it;

        for (int k = 0; k < 256; k++)
        begin
            shadow_scancode[k] = 7'd0;
            shadow_valid[k] = 1'b0;
            gen_written[k] = 1'b0;
            gen_valid[k] = 1'b0;
        end
        for (int k = 0; k < 8; k++)
            status_seen[k] = 0;
        for (int k = 0; k < 16; k++)
        begin
            rv = $urandom;
            char_pool[k] = rv[7:0];
        end
        clear_report();

        push_arg(map_arg(8'h61, 7'd29, 1'b0), 0);
        push_arg(map_arg(8'h62, 7'd48, 1'b0), 0);
        push_arg(map_arg(8'h00, 7'd0, 1'b0), 0);
        push_arg(map_arg(8'hFF, 7'd127, 1'b0), 0);
        push_arg(key_arg(0, 1'b0), 0);
        push_arg(key_arg(7, 1'b0), 0);
        push_arg(key_arg(8, 1'b0), 0);
        push_arg(key_arg(39, 1'b0), 0);
        push_arg(char_arg(21'h61, 1'b0), 0);
        push_arg(char_arg(21'h162, 1'b0), 0);
        push_arg(char_arg(21'h2061, 1'b0), 0);
        push_arg(char_arg(21'h1F462, 1'b0), 0);
        push_arg(key_arg(63, 1'b1), 0);
        push_arg(key_arg(40, 1'b0), 0);
        push_arg(key_arg(1, 1'b0), 0);
        push_arg(map_arg(8'h63, 7'd30, 1'b0), 0);
        push_arg(char_arg(21'h61, 1'b1), 0);
        push_arg(raw_char(8'h61, 8'h00, 8'h00, 8'h00, 0, 1'b1), 0);
        push_arg(key_arg(2, 1'b0), 0);
        push_arg(raw_char(8'hC0, 8'h80, 8'h00, 8'h00, 2, 1'b0), 0);
        push_arg(clear_arg(1'b1), 0);
        push_arg(char_arg(21'h61, 1'b1), 0);
        push_arg(map_arg(8'hFF, 7'd127, 1'b1), 0);
        push_arg(char_arg(21'hFF, 1'b1), 0);
        push_arg(raw_char(8'hED, 8'hA0, 8'h80, 8'h00, 3, 1'b1), 0);
        push_arg(raw_char(8'hF4, 8'h90, 8'h80, 8'h80, 4, 1'b1), 0);
        push_arg(map_arg(8'h00, 7'd0, 1'b0), 0);
        push_arg(char_arg(21'h1F600, 1'b1), 0);
        push_arg(map_arg(8'h62, 7'd48, 1'b0), 0);
        push_arg(raw_char(8'h62, 8'hFF, 8'hFF, 8'hFF, 7, 1'b1), 0);
        drain_points.push_back(key_args.size());

        half_mark = key_args.size() + RANDOM_ARGS / 2;
        target = key_args.size() + RANDOM_ARGS;
        mid_drain_set = 1'b0;
        while (key_args.size() < target)
        begin
            nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int a = 0; a < nargs; a++)
            begin
                last = (a == nargs - 1);
                r = $urandom_range(0, 99);
                rv = $urandom;
                if (r < 20)
                    it = key_arg($urandom_range(0, 7), last);
                else if (r < 45)
                    it = key_arg($urandom_range(8, 39), last);
                else if (r < 82)
                    it = char_arg(pick_code_point(), last);
                else if (r < 87)
                    it = map_arg(rv[3] ? char_pool[rv[7:4]] : rv[15:8], pick_scancode(), last);
                else if (r < 89)
                    it = clear_arg(last);
                else if (r < 91)
                    it = key_arg($urandom_range(40, 63), last);
                else if (r < 94)
                    it = bad_char_arg(last);
                else
                begin
                    it = noise_item();
                    if (last)
                        it.last_arg = 1'b1;
                end
                push_arg(it, 80);
            end
            if (!mid_drain_set && key_args.size() >= half_mark)
            begin
                drain_points.push_back(key_args.size());
                mid_drain_set = 1'b1;
            end
        end
        push_arg(key_arg(0, 1'b1), 80);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (args_taken < key_args.size())
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_reports.size() != 0)
            flag_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
        $display("summary: %0d key arguments taken, %0d reports checked, %0d mismatches",
                 args_taken, reports_checked, mismatch_count);
        $display("summary: status ok %0d, unknown %0d, bad utf8 %0d, unmapped %0d, no usage %0d",
                 status_seen[ST_OK], status_seen[ST_UNKNOWN], status_seen[ST_BAD_UTF8],
                 status_seen[ST_NOT_MAPPED], status_seen[ST_NO_USAGE]);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/hkrb_pkg.sv
hw/rtl/hkrb_char_store.sv
hw/rtl/hkrb_report_acc.sv
hw/rtl/hid_keyboard_report_builder_unit.sv
tb/hid_keyboard_report_builder_unit_tb.sv
